/* design/lzrw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lzrw_pkg;

  localparam int WINDOW_SIZE   = 4096;
  localparam int WIN_AW        = $clog2(WINDOW_SIZE);
  localparam int FILL_W        = $clog2(WINDOW_SIZE + 1);
  localparam int LENGTH_BIAS   = 2;
  localparam int STAGING_DEPTH = 512;
  localparam int STG_AW        = $clog2(STAGING_DEPTH);
  localparam int LEN_W         = $clog2(STAGING_DEPTH + 1);
  localparam int POS_W         = 12;
  localparam int EXT_LEN_W     = 11;

  localparam logic [3:0] NIB_ESC = 4'hF;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_LIT   = 2'd1,
    CMD_MATCH = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [7:0]         data;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   len;
    logic               last;
  } cmd_t;

endpackage
`default_nettype wire

/* design/lzss_ring_window_decoder_top.sv */
// Flag bytes, literals, ignored bytes and first match bytes: the result passes from the
// command queue through the idle and finish states into the output register. A match runs
// the 12-step remainder unit and the two serial copies, window to staging and staging to
// window, a read and a write state per byte. Bytes enter while the two-token queue has room.
// Asynchronous active-low reset clears all control state; window and staging
// memories hold no reset value and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module lzss_ring_window_decoder_top import lzrw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             run_end_o,
  output logic             stream_done_o,
  output logic [1:0]       status_o
);

  cmd_t push_cmd, pop_cmd;
  logic q_push, q_full, q_pop, q_valid;

  lzrw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd)
  );

  lzrw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (pop_cmd),
    .valid_o (q_valid)
  );

  lzrw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (pop_cmd),
    .cmd_pop_o     (q_pop),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_bytes_o   (out_bytes_o),
    .byte_count_o  (byte_count_o),
    .run_end_o     (run_end_o),
    .stream_done_o (stream_done_o),
    .status_o      (status_o)
  );

endmodule
`default_nettype wire

/* design/lzrw_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module lzrw_front import lzrw_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output cmd_t            q_cmd_o
);

  logic [8:0]       flag_q, flag_d;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       low_q, low_d;
  logic [POS_W-1:0] hpos_q, hpos_d;
  logic [POS_W-1:0] pos_now;
  logic [EXT_LEN_W-1:0] n_raw;
  logic [EXT_LEN_W-1:0] n_clamp;
  logic             esc;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    flag_d  = flag_q;
    phase_d = phase_q;
    low_d   = low_q;
    hpos_d  = hpos_q;
    pos_now = {data_byte_i, low_q[7:4]};
    esc     = (low_q[3:0] == NIB_ESC);
    if (phase_q == 2'd2) begin
      n_raw = EXT_LEN_W'(NIB_ESC) + EXT_LEN_W'(data_byte_i) + EXT_LEN_W'(LENGTH_BIAS + 1);
    end else begin
      n_raw = EXT_LEN_W'(low_q[3:0]) + EXT_LEN_W'(LENGTH_BIAS + 1);
    end
    n_clamp = (n_raw > EXT_LEN_W'(STAGING_DEPTH)) ? EXT_LEN_W'(STAGING_DEPTH) : n_raw;
    q_cmd_o = '{kind: CMD_NONE, data: data_byte_i, pos: hpos_q,
                len: n_clamp[LEN_W-1:0], last: last_byte_i};
    unique case (phase_q)
      2'd0: begin
        if (flag_q <= 9'd1) begin
          flag_d = {1'b1, data_byte_i};
        end else begin
          flag_d = {1'b0, flag_q[8:1]};
          if (flag_q[0]) begin
            q_cmd_o.kind = CMD_LIT;
          end else begin
            low_d   = data_byte_i;
            phase_d = 2'd1;
          end
        end
      end
      2'd1: begin
        hpos_d = pos_now;
        if (esc && !last_byte_i) begin
          phase_d = 2'd2;
        end else begin
          phase_d       = 2'd0;
          q_cmd_o.kind  = CMD_MATCH;
          q_cmd_o.pos   = pos_now;
        end
      end
      2'd2: begin
        phase_d      = 2'd0;
        q_cmd_o.kind = CMD_MATCH;
      end
      default: begin
        phase_d = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= '0;
      phase_q <= '0;
      low_q   <= '0;
      hpos_q  <= '0;
    end else if (q_push_o) begin
      if (last_byte_i) begin
        flag_q  <= '0;
        phase_q <= '0;
        low_q   <= '0;
        hpos_q  <= '0;
      end else begin
        flag_q  <= flag_d;
        phase_q <= phase_d;
        low_q   <= low_d;
        hpos_q  <= hpos_d;
      end
    end
  end

endmodule
`default_nettype wire

/* design/lzrw_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module lzrw_fifo import lzrw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      din_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      dout_o,
  output logic      valid_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

/* design/lzrw_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
module lzrw_mod import lzrw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [POS_W-1:0]  dividend_i,
  input  wire logic [FILL_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [FILL_W-1:0]      rem_o
);

  localparam int CNT_W = $clog2(POS_W + 1);

  logic [FILL_W-1:0] rem_q;
  logic [POS_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic [FILL_W:0]   trial;

  assign trial  = {rem_q, dvd_q[POS_W-1]};
  assign rem_o  = rem_q;
  assign done_o = busy_q && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvd_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      dvd_q  <= dividend_i;
      cnt_q  <= CNT_W'(POS_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
        dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          rem_q <= FILL_W'(trial - {1'b0, divisor_i});
        end else begin
          rem_q <= FILL_W'(trial);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* design/lzrw_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module lzrw_back import lzrw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             run_end_o,
  output logic             stream_done_o,
  output logic [1:0]       status_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_WRD  = 3'd2;
  localparam logic [2:0] S_WST  = 3'd3;
  localparam logic [2:0] S_SRD  = 3'd4;
  localparam logic [2:0] S_USE  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [7:0] window_mem  [WINDOW_SIZE];
  logic [7:0] staging_mem [STAGING_DEPTH];

  logic [2:0]        state_q;
  logic [31:0]       expected_q;
  logic [WIN_AW-1:0] wp_q;
  logic [FILL_W-1:0] fill_q;
  logic [31:0]       produced_q;
  logic [1:0]        status_q;
  cmd_t              cmd_q;
  logic [WIN_AW-1:0] idx_q;
  logic [LEN_W-1:0]  k_q;
  logic [7:0]        pk_q [8];
  logic [3:0]        pk_cnt_q;
  logic [7:0]        win_rd_q;
  logic [7:0]        stg_rd_q;

  logic              slot_free, emit_ok, use_go, k_last;
  logic              win_we, out_push, mod_start, mod_done;
  logic [7:0]        win_wdata;
  logic [1:0]        status_fin;
  logic [63:0]       pk_word;
  logic [FILL_W-1:0] mod_rem;
  logic              idle_run;

  lzrw_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (cmd_i.pos),
    .divisor_i  (fill_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign slot_free = !out_valid_o || out_ready_i;
  assign emit_ok   = (produced_q < expected_q);
  assign use_go    = !(emit_ok && (pk_cnt_q == 4'd8) && !slot_free);
  assign k_last    = ((k_q + 1'b1) == cmd_q.len);
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign idle_run  = cmd_pop_o && (status_q == ST_RUN) && emit_ok;
  assign mod_start = idle_run && (cmd_i.kind == CMD_MATCH) && (fill_q != '0);
  assign win_we    = (idle_run && (cmd_i.kind == CMD_LIT)) || ((state_q == S_USE) && use_go);
  assign win_wdata = (state_q == S_IDLE) ? cmd_i.data : stg_rd_q;
  assign out_push  = ((state_q == S_USE) && use_go && emit_ok && (pk_cnt_q == 4'd8))
                   || ((state_q == S_FIN) && slot_free);

  always_comb begin
    status_fin = status_q;
    if ((status_fin == ST_RUN) && !emit_ok) begin
      status_fin = ST_OK;
    end
    if ((status_fin == ST_RUN) && cmd_q.last) begin
      status_fin = ST_SHORT;
    end
    for (int i = 0; i < 8; i++) begin
      pk_word[8*i +: 8] = pk_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      window_mem[wp_q] <= win_wdata;
    end
    if (state_q == S_WRD) begin
      win_rd_q <= window_mem[idx_q];
    end
    if (state_q == S_WST) begin
      staging_mem[k_q[STG_AW-1:0]] <= win_rd_q;
    end
    if (state_q == S_SRD) begin
      stg_rd_q <= staging_mem[k_q[STG_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      expected_q    <= 32'd1;
      wp_q          <= '0;
      fill_q        <= '0;
      produced_q    <= '0;
      status_q      <= ST_RUN;
      cmd_q         <= '0;
      idx_q         <= '0;
      k_q           <= '0;
      pk_cnt_q      <= '0;
      for (int i = 0; i < 8; i++) begin
        pk_q[i] <= '0;
      end
      out_valid_o   <= 1'b0;
      out_bytes_o   <= '0;
      byte_count_o  <= '0;
      run_end_o     <= 1'b0;
      stream_done_o <= 1'b0;
      status_o      <= ST_RUN;
    end else begin
      if (cfg_we_i) begin
        expected_q <= cfg_wdata_i;
      end

      if (win_we) begin
        wp_q <= (wp_q == WIN_AW'(WINDOW_SIZE - 1)) ? '0 : wp_q + 1'b1;
        if (fill_q < FILL_W'(WINDOW_SIZE)) begin
          fill_q <= fill_q + 1'b1;
        end
      end

      if (out_push) begin
        out_valid_o <= 1'b1;
        out_bytes_o <= pk_word;
        if (state_q == S_FIN) begin
          byte_count_o  <= pk_cnt_q;
          run_end_o     <= 1'b1;
          stream_done_o <= (status_fin != ST_RUN);
          status_o      <= status_fin;
        end else begin
          byte_count_o  <= 4'd8;
          run_end_o     <= 1'b0;
          stream_done_o <= 1'b0;
          status_o      <= ST_RUN;
        end
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            cmd_q    <= cmd_i;
            pk_cnt_q <= '0;
            for (int i = 0; i < 8; i++) begin
              pk_q[i] <= '0;
            end
            state_q <= S_FIN;
            if (idle_run) begin
              case (cmd_i.kind)
                CMD_LIT: begin
                  pk_q[0]    <= cmd_i.data;
                  pk_cnt_q   <= 4'd1;
                  produced_q <= produced_q + 1'b1;
                end
                CMD_MATCH: begin
                  if (fill_q == '0) begin
                    status_q <= ST_EMPTY;
                  end else begin
                    state_q <= S_MOD;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            idx_q   <= mod_rem[WIN_AW-1:0];
            k_q     <= '0;
            state_q <= S_WRD;
          end
        end
        S_WRD: begin
          idx_q   <= ((FILL_W'(idx_q) + 1'b1) == fill_q) ? '0 : idx_q + 1'b1;
          state_q <= S_WST;
        end
        S_WST: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= S_SRD;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_WRD;
          end
        end
        S_SRD: begin
          state_q <= S_USE;
        end
        S_USE: begin
          if (use_go) begin
            if (emit_ok) begin
              produced_q <= produced_q + 1'b1;
              if (pk_cnt_q == 4'd8) begin
                for (int i = 1; i < 8; i++) begin
                  pk_q[i] <= '0;
                end
                pk_q[0]  <= stg_rd_q;
                pk_cnt_q <= 4'd1;
              end else begin
                pk_q[pk_cnt_q[2:0]] <= stg_rd_q;
                pk_cnt_q            <= pk_cnt_q + 1'b1;
              end
            end
            if (k_last) begin
              state_q <= S_FIN;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_SRD;
            end
          end
        end
        S_FIN: begin
          if (slot_free) begin
            state_q <= S_IDLE;
            if (cmd_q.last) begin
              wp_q       <= '0;
              fill_q     <= '0;
              produced_q <= '0;
              status_q   <= ST_RUN;
            end else begin
              status_q <= status_fin;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
